/* design/md5_pkg.sv */
// Package for the MD5 stream hasher: shared types, constants and round tables.
`timescale 1ns / 1ps
`default_nettype none
package md5_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  // Per-block job handed from the packer to the compression engine.
  typedef struct packed {
    logic [511:0] block;
    logic         close;  // emit digest and restart after this block
  } blk_job_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_RUN   = 2'd1,
    ST_ADD   = 2'd2,
    ST_EMIT  = 2'd3
  } eng_state_t;

  typedef enum logic [1:0] {
    PK_BYTES = 2'd0,
    PK_PAD1  = 2'd1,
    PK_PAD2  = 2'd2
  } pk_state_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] round_g(input logic [5:0] r);
    logic [3:0] g;
    case (r[5:4])
      2'd0: g = r[3:0];
      2'd1: g = 4'(5 * r[3:0] + 1);
      2'd2: g = 4'(3 * r[3:0] + 5);
      default: g = 4'(7 * r[3:0]);
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

/* design/md5_stream_hasher.sv */
// Top level of the streaming MD5 hasher.
// Usage:
//   Input channel (in_valid / in_stall): one word per handshake carrying a
//   message byte, an end-of-message flag and a no-byte flag. A no-byte word
//   with end_of_message set closes a message without adding a byte.
//   Output channel (out_valid / out_stall): four words per message, A, B, C,
//   D of the digest, word_index 0..3, final_word set on D.
// Timing:
//   Bytes are taken one per cycle while a block fills, unless the job queue
//   is full or padding is being queued. Each full block is queued to the
//   compression engine, which runs one round per cycle: 64 rounds, then an
//   add step, then a return to idle where the next block is taken. The
//   sustained input rate is set by the engine; the job queue absorbs short
//   bursts. After the closing word the packer queues one or two padding
//   blocks; the digest follows once the engine has added in the last block.
// Reset: synchronous, active low; chaining value returns to the MD5
//   initial value and the byte count clears.
// Stall: while out_stall is high the current digest word holds; the
//   engine waits, the queue fills, and in_stall rises behind it.
`timescale 1ns / 1ps
`default_nettype none
module md5_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_message,
  input  wire logic        in_no_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [1:0]       out_word_index,
  output logic             out_final_word
);

  md5_pkg::blk_job_t push_job, head_job;
  logic push, full, pop, avail;

  md5_packer u_pack (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_byte, .in_end_of_message,
    .in_no_byte, .job_valid(push), .job(push_job), .job_full(full)
  );

  md5_job_queue u_q (
    .clk, .rst_n, .push, .push_job, .full, .pop, .not_empty(avail),
    .head(head_job)
  );

  md5_engine u_eng (
    .clk, .rst_n, .job_avail(avail), .job(head_job), .job_pop(pop),
    .out_valid, .out_stall, .out_digest_word, .out_word_index, .out_final_word
  );

endmodule
`default_nettype wire

/* design/md5_packer.sv */
// Front end: packs bytes into 512-bit blocks and builds the padding blocks.
`timescale 1ns / 1ps
`default_nettype none
module md5_packer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_end_of_message,
  input  wire logic              in_no_byte,
  output logic                   job_valid,
  output md5_pkg::blk_job_t      job,
  input  wire logic              job_full
);

  md5_pkg::pk_state_t state_r, state_nxt;
  logic [511:0] blk_r, blk_nxt;
  logic [60:0]  cnt_r, cnt_nxt;
  logic         acc;
  logic [5:0]   pos;
  logic [5:0]   ppos;
  logic [60:0]  cnt_b;
  logic [511:0] blk_b;
  logic [511:0] padded;
  logic [63:0]  bits;

  assign in_stall = (state_r != md5_pkg::PK_BYTES) || job_full;
  assign acc = in_valid && !in_stall;
  assign pos = cnt_r[5:0];

  // block with the optional byte written, count after it
  always_comb begin
    blk_b = blk_r;
    cnt_b = cnt_r;
    if (acc && !in_no_byte) begin
      blk_b[{pos, 3'b000} +: 8] = in_data_byte;
      cnt_b = cnt_r + 61'd1;
    end
  end

  assign ppos = cnt_b[5:0];
  assign bits = {cnt_b, 3'b000};

  always_comb begin
    padded = blk_b;
    for (int i = 0; i < 64; i++) begin
      if (6'(i) == ppos) padded[i*8 +: 8] = md5_pkg::PAD_BYTE;
      else if (6'(i) > ppos) padded[i*8 +: 8] = 8'h00;
    end
  end

  always_comb begin
    state_nxt = state_r;
    blk_nxt   = blk_r;
    cnt_nxt   = cnt_r;
    job_valid = 1'b0;
    job.block = blk_b;
    job.close = 1'b0;
    unique case (state_r)
      md5_pkg::PK_BYTES: begin
        if (acc) begin
          blk_nxt = blk_b;
          cnt_nxt = cnt_b;
          if (!in_no_byte && pos == 6'd63) begin
            job_valid = 1'b1;
            job.block = blk_b;
          end
          if (in_end_of_message) begin
            // padding waits for the full-block job to be queued first
            if (!in_no_byte && pos == 6'd63) state_nxt = md5_pkg::PK_PAD1;
            else begin
              blk_nxt = padded;
              state_nxt = (ppos >= 6'd56) ? md5_pkg::PK_PAD1 : md5_pkg::PK_PAD2;
            end
          end
        end
      end
      md5_pkg::PK_PAD1: begin
        // pad block when position was 0 (just flushed), or overflow block
        job.block = (pos == 6'd0) ? {bits, 448'd0} | 512'(md5_pkg::PAD_BYTE) : blk_r;
        if (!job_full) begin
          job_valid = 1'b1;
          if (pos == 6'd0) begin
            job.close = 1'b1;
            cnt_nxt = '0;
            state_nxt = md5_pkg::PK_BYTES;
          end else begin
            blk_nxt = '0;
            state_nxt = md5_pkg::PK_PAD2;
          end
        end
      end
      md5_pkg::PK_PAD2: begin
        job.block = {bits, blk_r[447:0]};
        job.close = 1'b1;
        if (!job_full) begin
          job_valid = 1'b1;
          cnt_nxt = '0;
          state_nxt = md5_pkg::PK_BYTES;
        end
      end
      default: state_nxt = md5_pkg::PK_BYTES;
    endcase
  end

  // in PAD states cnt_b equals cnt_r since no byte is taken there
  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    if (!rst_n) begin
      state_r <= md5_pkg::PK_BYTES;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/md5_job_queue.sv */
// Small FIFO of block jobs between packer and compression engine.
`timescale 1ns / 1ps
`default_nettype none
module md5_job_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire md5_pkg::blk_job_t push_job,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output md5_pkg::blk_job_t      head
);

  md5_pkg::blk_job_t mem_r [md5_pkg::QDEPTH];
  logic [md5_pkg::QAW-1:0] wp_r, rp_r;
  logic [md5_pkg::QAW:0]   cnt_r;

  // full reserves one slot so the packer can queue back-to-back jobs safely
  assign full = (cnt_r >= (md5_pkg::QAW+1)'(md5_pkg::QDEPTH - 1));
  assign not_empty = (cnt_r != '0);
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (md5_pkg::QAW+1)'(push) - (md5_pkg::QAW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

/* design/md5_engine.sv */
// Back end: one MD5 round per cycle, chaining value and digest output.
`timescale 1ns / 1ps
`default_nettype none
module md5_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_avail,
  input  wire md5_pkg::blk_job_t job,
  output logic                   job_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [31:0]            out_digest_word,
  output logic [1:0]             out_word_index,
  output logic                   out_final_word
);

  md5_pkg::eng_state_t state_r, state_nxt;
  logic [31:0] cv_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [511:0] blk_r;
  logic         close_r;
  logic [5:0]   rnd_r;
  logic [1:0]   idx_r;
  logic [31:0]  f, sum, rot, mw;
  logic [4:0]   sh;

  always_comb begin
    unique case (rnd_r[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (d_r & b_r) | (~d_r & c_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
  end
  assign mw  = blk_r[{md5_pkg::round_g(rnd_r), 5'd0} +: 32];
  assign sum = a_r + f + md5_pkg::round_k(rnd_r) + mw;
  assign sh  = md5_pkg::round_s(rnd_r);
  assign rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      md5_pkg::ST_IDLE: if (job_avail) state_nxt = md5_pkg::ST_RUN;
      md5_pkg::ST_RUN:  if (rnd_r == 6'd63) state_nxt = md5_pkg::ST_ADD;
      md5_pkg::ST_ADD:  state_nxt = close_r ? md5_pkg::ST_EMIT : md5_pkg::ST_IDLE;
      md5_pkg::ST_EMIT: if (!out_stall && idx_r == 2'd3) state_nxt = md5_pkg::ST_IDLE;
      default: state_nxt = md5_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    job_pop = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      md5_pkg::ST_IDLE: job_pop = job_avail;
      md5_pkg::ST_EMIT: out_valid = 1'b1;
      default: ;
    endcase
  end

  assign out_digest_word = cv_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_final_word  = (idx_r == 2'd3);

  always_ff @(posedge clk) begin
    if (job_pop) begin
      blk_r <= job.block;
      close_r <= job.close;
      a_r <= cv_r[0]; b_r <= cv_r[1]; c_r <= cv_r[2]; d_r <= cv_r[3];
    end else if (state_r == md5_pkg::ST_RUN) begin
      a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= b_r + rot;
    end
    if (!rst_n) begin
      state_r <= md5_pkg::ST_IDLE;
      rnd_r <= '0;
      idx_r <= '0;
      cv_r[0] <= md5_pkg::IV_A; cv_r[1] <= md5_pkg::IV_B;
      cv_r[2] <= md5_pkg::IV_C; cv_r[3] <= md5_pkg::IV_D;
    end else begin
      state_r <= state_nxt;
      if (state_r == md5_pkg::ST_RUN) rnd_r <= rnd_r + 6'd1;
      if (state_r == md5_pkg::ST_ADD) begin
        cv_r[0] <= cv_r[0] + a_r; cv_r[1] <= cv_r[1] + b_r;
        cv_r[2] <= cv_r[2] + c_r; cv_r[3] <= cv_r[3] + d_r;
      end
      if (state_r == md5_pkg::ST_EMIT && !out_stall) begin
        idx_r <= idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          cv_r[0] <= md5_pkg::IV_A; cv_r[1] <= md5_pkg::IV_B;
          cv_r[2] <= md5_pkg::IV_C; cv_r[3] <= md5_pkg::IV_D;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* design/md5_checker.sv */
// Port-level checker for the MD5 stream hasher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module md5_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_digest_word,
  input wire logic [1:0]  out_word_index,
  input wire logic        out_final_word
);

  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_final_word == (out_word_index == 2'd3)))
    else $error("final_word mismatch");

  a_next_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_final_word) |=>
      (out_valid && out_word_index == $past(out_word_index) + 2'd1))
    else $error("digest words not consecutive");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_digest_word)))
    else $error("stalled word changed");

  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_final_word) |=> !out_valid)
    else $error("word after final");

endmodule

bind md5_stream_hasher md5_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_digest_word, .out_word_index,
  .out_final_word
);
`default_nettype wire
